/* rtl/sfdl_pkg.sv */
// Package for the smoothed feedback delay line: shared widths, constants,
// the configuration register codes and the result word type.
// No dependencies.
`default_nettype none

package sfdl_pkg;

  localparam int STORE_DEPTH_DEF  = 65536;
  localparam int NUM_CHANNELS_DEF = 2;

  localparam int SAMPLE_W = 24;
  localparam int CFG_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int FRAC_W   = 16;

  // Smoothing coefficient 131/65536, close to 0.002.
  localparam int SMOOTH_COEF = 131;
  localparam int COEF_W      = 8;

  // Result queue; deep enough to cover the three pipeline stages at full rate.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CNT_W = 4;

  typedef enum logic [0:0] {
    REG_TARGET_DELAY  = 1'b0,
    REG_FEEDBACK_GAIN = 1'b1
  } cfg_reg_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    sample_t sample_out;
    logic    delay_active;
  } result_t;

endpackage

`default_nettype wire

/* rtl/sfdl_if.sv */
// Handshake interfaces of the smoothed feedback delay line: sample input,
// result output and configuration write channel.
// Depends on sfdl_pkg.
`default_nettype none

interface sfdl_in_if;
  logic             valid;
  logic             ready;
  logic             channel;
  sfdl_pkg::sample_t sample_in;
  modport source (output valid, output channel, output sample_in, input ready);
  modport sink (input valid, input channel, input sample_in, output ready);
endinterface

interface sfdl_out_if;
  logic             valid;
  logic             ready;
  sfdl_pkg::sample_t sample_out;
  logic             delay_active;
  modport source (output valid, output sample_out, output delay_active, input ready);
  modport sink (input valid, input sample_out, input delay_active, output ready);
endinterface

interface sfdl_cfg_if;
  logic                         valid;
  logic                         ready;
  sfdl_pkg::cfg_reg_t           index;
  logic [sfdl_pkg::CFG_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/smoothed_feedback_delay_line_unit.sv */
// Smoothed feedback delay line, top level. A word passes stages A, B and C and
// the result queue before it reaches the result channel. Throughput: one word
// per cycle while the queue has room, set by the single read and single write
// port of the delay memory. Reset: synchronous; it clears the registers, then a
// clearing sweep zeroes all NUM_CHANNELS * 2**clog2(STORE_DEPTH) memory entries
// (131072 at the defaults) while no sample word is accepted; cfg writes go in.
`default_nettype none

module smoothed_feedback_delay_line_unit #(
  parameter int STORE_DEPTH  = sfdl_pkg::STORE_DEPTH_DEF,
  parameter int NUM_CHANNELS = sfdl_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sfdl_in_if.sink     audio,
  sfdl_out_if.source  wet,
  sfdl_cfg_if.sink    cfg
);

  // Each channel owns a block of 2**PW memory entries; positions past
  // STORE_DEPTH-1, if any, are touched only by the clearing sweep.
  localparam int PW        = $clog2(STORE_DEPTH);
  localparam int CW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int AW        = CW + PW;
  localparam int MEM_DEPTH = NUM_CHANNELS << PW;
  localparam int SUM_W     = sfdl_pkg::SAMPLE_W + 3;
  localparam int PROD_W    = sfdl_pkg::SAMPLE_W + sfdl_pkg::GAIN_W + 1;
  localparam logic [PW-1:0] LAST_POS = PW'(STORE_DEPTH - 1);

  // Configuration registers. The port never stalls.
  logic [sfdl_pkg::CFG_W-1:0]  target_delay;
  logic [sfdl_pkg::GAIN_W-1:0] feedback_gain;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_delay  <= '0;
      feedback_gain <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        sfdl_pkg::REG_TARGET_DELAY:  target_delay  <= cfg.data;
        sfdl_pkg::REG_FEEDBACK_GAIN: feedback_gain <= cfg.data;
        default: ;
      endcase
    end
  end

  // The pipeline never stalls. Instead, a word is taken only when the result
  // queue has room for it and for every word already in the pipeline.
  logic                            clearing;
  logic [sfdl_pkg::FIFO_CNT_W-1:0] fifo_count;
  logic [sfdl_pkg::FIFO_CNT_W-1:0] committed;
  logic                            take;

  logic              a_valid;
  logic              a_chan;
  sfdl_pkg::sample_t a_sample;
  logic              b_valid;
  sfdl_pkg::sample_t b_sample;
  logic              c_valid;
  sfdl_pkg::sample_t c_sample;

  assign committed = fifo_count + sfdl_pkg::FIFO_CNT_W'(a_valid)
                   + sfdl_pkg::FIFO_CNT_W'(b_valid) + sfdl_pkg::FIFO_CNT_W'(c_valid);
  assign audio.ready = !clearing
                     && (committed < sfdl_pkg::FIFO_CNT_W'(sfdl_pkg::FIFO_DEPTH));
  assign take = audio.valid && audio.ready;

  // Stage A: the registered input word. The smoother reads and updates the
  // channel's smoothed delay within this stage, so the next word of the same
  // channel sees the new value.
  logic [CW-1:0] a_ch;
  logic          a_ok;
  logic [PW-1:0] a_whole;

  assign a_ch = CW'(a_chan);
  assign a_ok = ((CW + 1)'(a_chan) < (CW + 1)'(NUM_CHANNELS));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_chan   <= audio.channel;
      a_sample <= audio.sample_in;
    end
  end

  sfdl_smoother #(
    .STORE_DEPTH  (STORE_DEPTH),
    .NUM_CHANNELS (NUM_CHANNELS),
    .PW           (PW),
    .CW           (CW)
  ) u_smoother (
    .clk          (clk),
    .rst          (rst),
    .step         (a_valid && a_ok),
    .ch           (a_ch),
    .target_delay (target_delay),
    .whole        (a_whole)
  );

  // Stage B: compute the read position from the channel's write position and
  // the whole delay, issue the memory read and advance the write position.
  logic [CW-1:0] b_ch;
  logic          b_ok;
  logic [PW-1:0] b_whole;
  logic          b_active;
  logic [PW-1:0] b_wp;
  logic [PW:0]   b_rp_sum;
  logic [PW-1:0] b_rp;
  logic [PW-1:0] b_wp_next;
  logic [PW-1:0] write_position [NUM_CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_ch     <= a_ch;
    b_ok     <= a_ok;
    b_whole  <= a_whole;
    b_sample <= a_sample;
  end

  always_comb begin
    b_active  = b_ok && (b_whole != '0);
    b_wp      = write_position[b_ch];
    // Circular subtraction: wrap by adding the store depth when needed.
    if (b_wp >= b_whole) begin
      b_rp_sum = {1'b0, b_wp} - {1'b0, b_whole};
    end else begin
      b_rp_sum = {1'b0, b_wp} + (PW + 1)'(STORE_DEPTH) - {1'b0, b_whole};
    end
    b_rp      = b_rp_sum[PW-1:0];
    b_wp_next = (b_wp == LAST_POS) ? '0 : (b_wp + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        write_position[i] <= '0;
      end
    end else if (b_valid && b_active) begin
      write_position[b_ch] <= b_wp_next;
    end
  end

  // Stage C: the delayed sample arrives from memory, is scaled by the feedback
  // gain, added to the input, saturated and written back at the old write
  // position. The memory forwards this write to a read of the same entry
  // issued in the same cycle by the next word.
  logic [CW-1:0]            c_ch;
  logic                     c_active;
  logic [PW-1:0]            c_wp;
  sfdl_pkg::sample_t        c_delayed;
  logic signed [PROD_W-1:0] c_prod;
  logic signed [PROD_W-1:0] c_fb;
  logic signed [SUM_W-1:0]  c_sum;
  sfdl_pkg::sample_t        c_sat;
  sfdl_pkg::result_t        c_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_ch     <= b_ch;
    c_active <= b_active;
    c_wp     <= b_wp;
    c_sample <= b_sample;
  end

  sfdl_store #(
    .MEM_DEPTH (MEM_DEPTH),
    .AW        (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (b_valid && b_active),
    .rd_addr  ({b_ch, b_rp}),
    .wr_en    (c_valid && c_active),
    .wr_addr  ({c_ch, c_wp}),
    .wr_data  (c_sat),
    .rd_data  (c_delayed),
    .clearing (clearing)
  );

  always_comb begin
    c_prod = c_delayed * $signed({1'b0, feedback_gain});
    // Round half up, then an arithmetic shift floors the result.
    c_fb   = (c_prod + PROD_W'(16384)) >>> 15;
    c_sum  = SUM_W'(c_sample) + $signed(c_fb[SUM_W-1:0]);
    if (c_sum > SUM_W'(sfdl_pkg::SAMPLE_MAX)) begin
      c_sat = sfdl_pkg::SAMPLE_MAX;
    end else if (c_sum < SUM_W'(sfdl_pkg::SAMPLE_MIN)) begin
      c_sat = sfdl_pkg::SAMPLE_MIN;
    end else begin
      c_sat = c_sum[sfdl_pkg::SAMPLE_W-1:0];
    end
    c_result.sample_out   = c_active ? c_delayed : c_sample;
    c_result.delay_active = c_active;
  end

  // Result queue decouples the pipeline from the output handshake.
  sfdl_pkg::result_t head;

  sfdl_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (c_valid),
    .push_data (c_result),
    .pop       (wet.valid && wet.ready),
    .head      (head),
    .not_empty (wet.valid),
    .count     (fifo_count)
  );

  assign wet.sample_out   = head.sample_out;
  assign wet.delay_active = head.delay_active;

endmodule

`default_nettype wire

/* rtl/sfdl_smoother.sv */
// Per-channel delay smoother: glides each channel's fixed-point delay toward
// the clamped target and reports the whole-sample part of the new value.
// Depends on sfdl_pkg.
`default_nettype none

module sfdl_smoother #(
  parameter int STORE_DEPTH  = sfdl_pkg::STORE_DEPTH_DEF,
  parameter int NUM_CHANNELS = sfdl_pkg::NUM_CHANNELS_DEF,
  parameter int PW           = $clog2(STORE_DEPTH),
  parameter int CW           = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [CW-1:0]              ch,
  input  logic [sfdl_pkg::CFG_W-1:0] target_delay,
  output logic [PW-1:0]              whole
);

  localparam int SW  = PW + sfdl_pkg::FRAC_W;
  localparam int PRW = SW + sfdl_pkg::COEF_W;
  localparam int TW  = (PW > sfdl_pkg::CFG_W) ? PW : sfdl_pkg::CFG_W;
  localparam logic [TW-1:0] LAST_T = TW'(STORE_DEPTH - 1);

  logic [SW-1:0]  smoothed [NUM_CHANNELS];
  logic [SW-1:0]  s_cur;
  logic [SW-1:0]  s_next;
  logic [SW-1:0]  tgt;
  logic [SW-1:0]  diff;
  logic [SW-1:0]  mag;
  logic [PRW-1:0] scaled;
  logic [TW-1:0]  tgt_ext;
  logic [PW-1:0]  tgt_whole;
  logic           up;

  always_comb begin
    tgt_ext   = TW'(target_delay);
    tgt_whole = (tgt_ext > LAST_T) ? LAST_T[PW-1:0] : tgt_ext[PW-1:0];
    tgt       = {tgt_whole, {sfdl_pkg::FRAC_W{1'b0}}};
    s_cur     = smoothed[ch];
    up        = (tgt >= s_cur);
    diff      = up ? (tgt - s_cur) : (s_cur - tgt);
    // Rounded-up step: ceil(diff * 131 / 65536).
    scaled    = PRW'(diff) * PRW'(sfdl_pkg::SMOOTH_COEF)
              + PRW'({sfdl_pkg::FRAC_W{1'b1}});
    mag       = SW'(scaled >> sfdl_pkg::FRAC_W);
    s_next    = up ? (s_cur + mag) : (s_cur - mag);
    whole     = s_next[SW-1:sfdl_pkg::FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        smoothed[i] <= '0;
      end
    end else if (step) begin
      smoothed[ch] <= s_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/sfdl_store.sv */
// Delay sample memory: one write and one registered read per cycle, with
// write-to-read forwarding and a clearing sweep after reset.
// Depends on sfdl_pkg.
`default_nettype none

module sfdl_store #(
  parameter int MEM_DEPTH = sfdl_pkg::NUM_CHANNELS_DEF * sfdl_pkg::STORE_DEPTH_DEF,
  parameter int AW        = $clog2(MEM_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  sfdl_pkg::sample_t wr_data,
  output sfdl_pkg::sample_t rd_data,
  output logic              clearing
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

  sfdl_pkg::sample_t mem [MEM_DEPTH];
  logic [AW-1:0]     clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // A write in the same cycle to the address being read wins.
    if (rd_en) begin
      rd_data <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/sfdl_result_fifo.sv */
// Small result queue between the delay pipeline and the output channel.
// Depends on sfdl_pkg.
`default_nettype none

module sfdl_result_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  sfdl_pkg::result_t               push_data,
  input  logic                            pop,
  output sfdl_pkg::result_t               head,
  output logic                            not_empty,
  output logic [sfdl_pkg::FIFO_CNT_W-1:0] count
);

  sfdl_pkg::result_t                 slots [sfdl_pkg::FIFO_DEPTH];
  logic [sfdl_pkg::FIFO_AW-1:0]      wr_ptr;
  logic [sfdl_pkg::FIFO_AW-1:0]      rd_ptr;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/sfdl_checker.sv */
// Port-level checker for the smoothed feedback delay line and the bind that
// attaches it to the top level. Depends on sfdl_pkg and the top level.
`default_nettype none

module sfdl_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       audio_valid,
  input logic                       audio_ready,
  input logic                       wet_valid,
  input logic                       wet_ready,
  input sfdl_pkg::sample_t          sample_out,
  input logic                       delay_active,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input sfdl_pkg::cfg_reg_t         cfg_index,
  input logic [sfdl_pkg::CFG_W-1:0] cfg_data
);

  logic [sfdl_pkg::FIFO_CNT_W-1:0] outstanding;
  logic                            target_seen;
  logic                            in_take;
  logic                            out_take;

  assign in_take  = audio_valid && audio_ready;
  assign out_take = wet_valid && wet_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      target_seen <= 1'b0;
    end else begin
      if (in_take && !out_take) begin
        outstanding <= outstanding + 1'b1;
      end else if (out_take && !in_take) begin
        outstanding <= outstanding - 1'b1;
      end
      if (cfg_valid && cfg_ready && (cfg_index == sfdl_pkg::REG_TARGET_DELAY)
          && (cfg_data != '0)) begin
        target_seen <= 1'b1;
      end
    end
  end

  // The memory sweep after reset keeps the sample input closed.
  a_closed_after_reset: assert property (@(posedge clk) rst |=> !audio_ready)
    else $error("sample input open right after reset");

  a_no_result_from_nothing: assert property (@(posedge clk) disable iff (rst)
    wet_valid |-> (outstanding != '0))
    else $error("result shown with no word outstanding");

  a_bounded_in_flight: assert property (@(posedge clk) disable iff (rst)
    outstanding <= sfdl_pkg::FIFO_CNT_W'(sfdl_pkg::FIFO_DEPTH))
    else $error("more words in flight than the result queue holds");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (wet_valid && !wet_ready) |=> (wet_valid && $stable(sample_out)
                                   && $stable(delay_active)))
    else $error("stalled result changed");

  a_no_delay_without_target: assert property (@(posedge clk) disable iff (rst)
    (wet_valid && !target_seen) |-> !delay_active)
    else $error("delayed result while the target delay was never set");

endmodule

bind smoothed_feedback_delay_line_unit sfdl_checker u_sfdl_checker (
  .clk          (clk),
  .rst          (rst),
  .audio_valid  (audio.valid),
  .audio_ready  (audio.ready),
  .wet_valid    (wet.valid),
  .wet_ready    (wet.ready),
  .sample_out   (wet.sample_out),
  .delay_active (wet.delay_active),
  .cfg_valid    (cfg.valid),
  .cfg_ready    (cfg.ready),
  .cfg_index    (cfg.index),
  .cfg_data     (cfg.data)
);

`default_nettype wire

/* tb/sfdl_echo_checker.sv */
`timescale 1ns / 100ps
// Checker for the smoothed feedback delay line: watches the sample, result and
// configuration channels, predicts each result word and compares it in order.
// Depends on sfdl_pkg and the interfaces in sfdl_if.
module sfdl_echo_checker (
  input  logic clk,
  input  logic rst,
  sfdl_in_if   audio,
  sfdl_out_if  wet,
  sfdl_cfg_if  cfg,
  output int   errors,
  output int   pending
);

  localparam int DEPTH = sfdl_pkg::STORE_DEPTH_DEF;
  localparam int LANES = sfdl_pkg::NUM_CHANNELS_DEF;

  logic [sfdl_pkg::CFG_W-1:0]  target_reg;
  logic [sfdl_pkg::GAIN_W-1:0] gain_reg;
  sfdl_pkg::sample_t           echo_mem [LANES][DEPTH];
  int unsigned                 wr_pos [LANES];
  longint unsigned             delay_q16 [LANES];
  sfdl_pkg::result_t           echo_due [$];

  // Advances one channel by one sample word and returns the word it should emit.
  function automatic sfdl_pkg::result_t predict_echo(input logic ch,
                                                     input sfdl_pkg::sample_t x);
    int                lane;
    int                clamp;
    longint unsigned   tgt;
    longint unsigned   mag;
    longint unsigned   whole;
    int unsigned       rp;
    sfdl_pkg::sample_t delayed;
    longint            fb;
    longint            sum;
    sfdl_pkg::result_t r;
    lane  = int'(ch);
    clamp = (target_reg > DEPTH - 1) ? DEPTH - 1 : int'(target_reg);
    tgt   = longint'(clamp) << sfdl_pkg::FRAC_W;
    // The glide step is rounded up, so the delay lands on the target exactly.
    if (tgt >= delay_q16[lane]) begin
      mag = ((tgt - delay_q16[lane]) * sfdl_pkg::SMOOTH_COEF + 65535) >> 16;
      delay_q16[lane] = delay_q16[lane] + mag;
    end else begin
      mag = ((delay_q16[lane] - tgt) * sfdl_pkg::SMOOTH_COEF + 65535) >> 16;
      delay_q16[lane] = delay_q16[lane] - mag;
    end
    whole = delay_q16[lane] >> sfdl_pkg::FRAC_W;
    if (whole == 0) begin
      r.sample_out   = x;
      r.delay_active = 1'b0;
      return r;
    end
    if (whole > DEPTH - 1) whole = DEPTH - 1;
    rp      = 32'((longint'(wr_pos[lane]) + DEPTH - whole) % DEPTH);
    delayed = echo_mem[lane][rp];
    // Gain product rounded half up: add half an LSB, then floor by shifting.
    fb  = (longint'(delayed) * longint'(gain_reg) + 16384) >>> 15;
    sum = longint'(x) + fb;
    if (sum > sfdl_pkg::SAMPLE_MAX) sum = sfdl_pkg::SAMPLE_MAX;
    if (sum < sfdl_pkg::SAMPLE_MIN) sum = sfdl_pkg::SAMPLE_MIN;
    echo_mem[lane][wr_pos[lane]] = sum[sfdl_pkg::SAMPLE_W-1:0];
    wr_pos[lane] = (wr_pos[lane] + 1) % DEPTH;
    r.sample_out   = delayed;
    r.delay_active = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    sfdl_pkg::result_t want;
    if (rst) begin
      errors     = 0;
      target_reg = '0;
      gain_reg   = '0;
      echo_due.delete();
      for (int l = 0; l < LANES; l++) begin
        wr_pos[l]    = 0;
        delay_q16[l] = 0;
        for (int a = 0; a < DEPTH; a++) echo_mem[l][a] = '0;
      end
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          sfdl_pkg::REG_TARGET_DELAY:  target_reg = cfg.data;
          sfdl_pkg::REG_FEEDBACK_GAIN: gain_reg   = cfg.data;
          default: ;
        endcase
      end
      if (wet.valid && wet.ready) begin
        if (echo_due.size() == 0) begin
          $error("result word with nothing expected: sample_out=%0d delay_active=%0b",
                 wet.sample_out, wet.delay_active);
          errors++;
        end else begin
          want = echo_due.pop_front();
          if (wet.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, got %0d", want.sample_out, wet.sample_out);
            errors++;
          end
          if (wet.delay_active !== want.delay_active) begin
            $error("delay_active: expected %0b, got %0b", want.delay_active,
                   wet.delay_active);
            errors++;
          end
        end
      end
      // A word accepted now cannot be answered at this same edge, so it is
      // queued after the result above has been matched.
      if (audio.valid && audio.ready)
        echo_due.push_back(predict_echo(audio.channel, audio.sample_in));
    end
    pending = echo_due.size();
  end

endmodule

/* tb/smoothed_feedback_delay_line_unit_tb.sv */
`timescale 1ns / 100ps
// Top of the smoothed feedback delay line testbench: clock, reset, stimulus
// on the sample and configuration channels, result-side stalls and the verdict.
// Depends on sfdl_pkg, sfdl_if, the block itself and sfdl_echo_checker.
module smoothed_feedback_delay_line_unit_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;

  // Steers which channels the sample words go to: 0 both at random,
  // 1 only channel zero, 2 only channel one.
  int   lane_mode = 0;

  sfdl_in_if  audio ();
  sfdl_out_if wet ();
  sfdl_cfg_if cfg ();

  smoothed_feedback_delay_line_unit DUT (
    .clk   (clk),
    .rst   (rst),
    .audio (audio),
    .wet   (wet),
    .cfg   (cfg)
  );

  sfdl_echo_checker echo_check (
    .clk     (clk),
    .rst     (rst),
    .audio   (audio),
    .wet     (wet),
    .cfg     (cfg),
    .errors  (errors),
    .pending (pending)
  );

  always #1 clk = ~clk;

  // Every input is changed at the falling edge and the block samples it at the
  // rising edge, so nothing here races the block's own registers.

  // Writes one register and returns at a falling edge with the channel idle.
  task automatic write_reg(input sfdl_pkg::cfg_reg_t idx,
                           input logic [sfdl_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic configure(input logic [sfdl_pkg::CFG_W-1:0] delay,
                           input logic [sfdl_pkg::CFG_W-1:0] gain);
    write_reg(sfdl_pkg::REG_TARGET_DELAY, delay);
    write_reg(sfdl_pkg::REG_FEEDBACK_GAIN, gain);
  endtask

  // Offers one sample word, starting at a falling edge, and returns at the
  // falling edge after it was taken with valid still high. The caller either
  // puts up the next word right away or lowers valid for a gap.
  task automatic send_word(input logic ch, input sfdl_pkg::sample_t s);
    audio.channel   = ch;
    audio.sample_in = s;
    audio.valid     = 1'b1;
    @(posedge clk);
    while (!audio.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic pick_channel();
    case (lane_mode)
      1:       return 1'b0;
      2:       return 1'b1;
      default: return 1'(($urandom_range(0, 1)));
    endcase
  endfunction

  // Mostly full-scale random audio, with the rails and near-silence mixed in
  // so that both saturation limits and tiny feedback products show up.
  function automatic sfdl_pkg::sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return sfdl_pkg::SAMPLE_MAX;
      1:       return sfdl_pkg::SAMPLE_MIN;
      2:       return sfdl_pkg::sample_t'(int'($urandom_range(0, 64)) - 32);
      default: return sfdl_pkg::sample_t'($urandom);
    endcase
  endfunction

  // Sends n random words in bursts of random length; gap_max of zero means
  // the sender never idles in this phase.
  task automatic run_phase(input int n, input int gap_max);
    int burst;
    burst = $urandom_range(1, 40);
    for (int i = 0; i < n; i++) begin
      send_word(pick_channel(), pick_sample());
      burst--;
      if (burst == 0) begin
        if (gap_max > 0) begin
          audio.valid = 1'b0;
          repeat ($urandom_range(1, gap_max)) @(negedge clk);
        end
        burst = $urandom_range(1, 40);
      end
    end
    audio.valid = 1'b0;
  endtask

  // Waits at falling edges until every expected word has come back, then waits
  // on so the pipeline is surely empty before a register write.
  task automatic settle();
    audio.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    audio.valid     = 1'b0;
    audio.channel   = 1'b0;
    audio.sample_in = '0;
    cfg.valid       = 1'b0;
    cfg.index       = sfdl_pkg::REG_TARGET_DELAY;
    cfg.data        = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // With a zero target the delay never leaves zero, so every word passes
    // straight through. The rails and alternating bit patterns go first.
    // These words wait out the memory clearing sweep that follows reset.
    configure(16'd0, 16'd0);
    send_word(1'b0, sfdl_pkg::SAMPLE_MAX);
    send_word(1'b1, sfdl_pkg::SAMPLE_MIN);
    send_word(1'b0, sfdl_pkg::sample_t'(0));
    send_word(1'b1, sfdl_pkg::sample_t'(-1));
    send_word(1'b0, sfdl_pkg::sample_t'(24'h555555));
    send_word(1'b1, sfdl_pkg::sample_t'(24'hAAAAAA));
    settle();

    // Short target with unity feedback. The delay glides up from zero, so the
    // first few dozen words per channel still pass through, then echoes of one
    // sample and upward start and build up toward the rails.
    configure(16'd12, 16'd32768);
    run_phase(350, 12);
    settle();

    // Gain above unity on a short delay drives the stored sum into saturation.
    // The long receiver hold-off falls in this phase.
    configure(16'($urandom_range(8, 24)), 16'hFFFF);
    run_phase(350, 6);
    settle();

    // No feedback, one channel only, and no idling on the sending side.
    lane_mode = 1;
    configure(16'($urandom_range(4, 30)), 16'd0);
    run_phase(250, 0);
    settle();

    // Target of one: the delay glides back down toward a single sample on the
    // other channel while the gain is random.
    lane_mode = 2;
    configure(16'd1, 16'($urandom));
    run_phase(300, 10);
    settle();

    // Random registers over their whole width; long delays read far back into
    // the store, where most entries are still cleared.
    lane_mode = 0;
    configure(16'($urandom), 16'($urandom));
    run_phase(300, 12);
    settle();

    // Both registers at their top values.
    configure(16'hFFFF, 16'hFFFF);
    run_phase(300, 8);
    settle();

    // Target back to zero: the long delay only starts to shrink.
    configure(16'd0, 16'($urandom_range(0, 32768)));
    run_phase(80, 4);
    settle();

    repeat (6) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side: stretches of always-ready, coin-flip, mostly-stalled and a
  // fixed rotating pattern. Once, after 500 words have been taken, ready stays
  // low for a long stretch while the sender keeps offering words, so the
  // block's result queue fills and it must hold off its input.
  initial begin : sink_side
    int          taken;
    int          mode;
    int          span;
    int          step;
    bit          held;
    logic [31:0] pattern;
    wet.ready = 1'b0;
    taken     = 0;
    held      = 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      span    = $urandom_range(20, 200);
      pattern = $urandom;
      for (step = 0; step < span; step++) begin
        @(posedge clk);
        if (wet.valid && wet.ready) taken++;
        @(negedge clk);
        if (!held && taken >= 500) begin
          held      = 1'b1;
          wet.ready = 1'b0;
          repeat (150) @(negedge clk);
        end
        case (mode)
          0:       wet.ready = 1'b1;
          1:       wet.ready = 1'($urandom_range(0, 1));
          2:       wet.ready = ($urandom_range(0, 4) == 0);
          default: wet.ready = pattern[step % 32];
        endcase
      end
    end
  end

  // The bound is several times what the clearing sweep and the rest of a slow
  // run take together.
  initial begin : watchdog
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
